/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the XTEA cipher RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// Simulation gets the assertions; synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

/* hw/rtl/xtea_pkg.sv */
// Package for the XTEA cipher block: types, codes and constants.
// Used by xtea_regs, xtea_ctrl, xtea_dp and the top level.
package xtea_pkg;

  // Cipher constants.
  localparam logic [31:0] XteaDelta = 32'h9E3779B9;
  localparam int unsigned MaxRoundsDefault = 64;
  localparam logic [6:0] RoundCountReset = 7'd32;

  // Configuration port geometry: 64-bit data, registers every 8 bytes.
  localparam int unsigned PaddrW = 6;
  localparam int unsigned PdataW = 64;

  // Register indexes, taken from paddr[5:3].
  typedef enum logic [2:0] {
    REG_KEY0       = 3'd0,
    REG_KEY1       = 3'd1,
    REG_KEY2       = 3'd2,
    REG_KEY3       = 3'd3,
    REG_MODE       = 3'd4,
    REG_ROUNDS     = 3'd5,
    REG_CHAIN_INIT = 3'd6
  } reg_idx_e;

  // Cipher modes. Codes above MODE_CTR behave as MODE_ENC.
  typedef enum logic [2:0] {
    MODE_ENC     = 3'd0,
    MODE_DEC     = 3'd1,
    MODE_CBC_ENC = 3'd2,
    MODE_CBC_DEC = 3'd3,
    MODE_CTR     = 3'd4
  } mode_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINISH
  } ctrl_state_e;

  // Input and result transactions.
  typedef struct packed {
    logic [31:0] word_low;
    logic [31:0] word_high;
    logic        restart_chain;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_low;
    logic [31:0] out_high;
  } out_item_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [3:0][31:0] key;
    logic [2:0]       mode;
    logic [6:0]       round_count;
    logic [63:0]      chain_init;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rounds_zero;
    logic last_round;
    logic out_free;
  } dp_sts_t;

  // Mixing function of one half round.
  function automatic logic [31:0] mix(input logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

/* hw/rtl/xtea_regs.sv */
// Configuration register file behind an APB-style port.
// Depends on xtea_pkg for register indexes, widths and the cfg_t type.
module xtea_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [xtea_pkg::PaddrW-1:0]  paddr,
  input  logic [xtea_pkg::PdataW-1:0]  pwdata,
  output logic [xtea_pkg::PdataW-1:0]  prdata,
  output logic                         pready,
  output xtea_pkg::cfg_t               cfg_o
);

  xtea_pkg::cfg_t   cfg_q;
  xtea_pkg::reg_idx_e reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = xtea_pkg::reg_idx_e'(paddr[5:3]);
  assign cfg_o   = cfg_q;

  // Register writes; an address beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key         <= '0;
      cfg_q.mode        <= xtea_pkg::MODE_ENC;
      cfg_q.round_count <= xtea_pkg::RoundCountReset;
      cfg_q.chain_init  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        xtea_pkg::REG_KEY0:       cfg_q.key[0]      <= pwdata[31:0];
        xtea_pkg::REG_KEY1:       cfg_q.key[1]      <= pwdata[31:0];
        xtea_pkg::REG_KEY2:       cfg_q.key[2]      <= pwdata[31:0];
        xtea_pkg::REG_KEY3:       cfg_q.key[3]      <= pwdata[31:0];
        xtea_pkg::REG_MODE:       cfg_q.mode        <= pwdata[2:0];
        xtea_pkg::REG_ROUNDS:     cfg_q.round_count <= pwdata[6:0];
        xtea_pkg::REG_CHAIN_INIT: cfg_q.chain_init  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_idx)
      xtea_pkg::REG_KEY0:       prdata = {32'd0, cfg_q.key[0]};
      xtea_pkg::REG_KEY1:       prdata = {32'd0, cfg_q.key[1]};
      xtea_pkg::REG_KEY2:       prdata = {32'd0, cfg_q.key[2]};
      xtea_pkg::REG_KEY3:       prdata = {32'd0, cfg_q.key[3]};
      xtea_pkg::REG_MODE:       prdata = {61'd0, cfg_q.mode};
      xtea_pkg::REG_ROUNDS:     prdata = {57'd0, cfg_q.round_count};
      xtea_pkg::REG_CHAIN_INIT: prdata = cfg_q.chain_init;
      default:                  prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/xtea_ctrl.sv */
// Controller state machine of the XTEA cipher block.
// Depends on xtea_pkg for the state enum and the command/status structs.
`include "assert_macros.svh"

module xtea_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  xtea_pkg::dp_sts_t sts_i,
  output xtea_pkg::dp_cmd_t cmd_o
);

  xtea_pkg::ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xtea_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      xtea_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = xtea_pkg::ST_LOAD;
      end
      xtea_pkg::ST_LOAD: begin
        state_d = sts_i.rounds_zero ? xtea_pkg::ST_FINISH : xtea_pkg::ST_ROUND;
      end
      xtea_pkg::ST_ROUND: begin
        if (sts_i.last_round) state_d = xtea_pkg::ST_FINISH;
      end
      xtea_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = xtea_pkg::ST_IDLE;
      end
      default: state_d = xtea_pkg::ST_IDLE;
    endcase
  end

  // Outputs: commands to the datapath and the input stall.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      xtea_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      xtea_pkg::ST_LOAD:   cmd_o.load   = 1'b1;
      xtea_pkg::ST_ROUND:  cmd_o.step   = 1'b1;
      xtea_pkg::ST_FINISH: cmd_o.finish = sts_i.out_free;
      default: ;
    endcase
  end

  // An accepted transaction always starts with the load cycle.
  `ASSERT_CLK(a_accept_to_load, cmd_o.accept |=> state_q == xtea_pkg::ST_LOAD)
  // The last round always hands over to the finish cycle.
  `ASSERT_CLK(a_last_to_finish,
              (state_q == xtea_pkg::ST_ROUND && sts_i.last_round)
              |=> state_q == xtea_pkg::ST_FINISH)
  // A result that cannot be written keeps the controller in finish.
  `ASSERT_CLK(a_finish_holds,
              (state_q == xtea_pkg::ST_FINISH && !sts_i.out_free)
              |=> state_q == xtea_pkg::ST_FINISH)

endmodule

/* hw/rtl/xtea_dp.sv */
// Datapath of the XTEA cipher block: round unit, chaining state, output register.
// Depends on xtea_pkg for types, constants and the mix function.
`include "assert_macros.svh"

module xtea_dp #(
  parameter int unsigned MaxRounds = xtea_pkg::MaxRoundsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  xtea_pkg::cfg_t     cfg_i,
  input  xtea_pkg::in_item_t in_data_i,
  input  xtea_pkg::dp_cmd_t  cmd_i,
  output xtea_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output xtea_pkg::out_item_t out_data_o
);

  localparam int unsigned RndW = $clog2(MaxRounds + 1);
  localparam int unsigned CmpW = (RndW > 7) ? RndW : 7;

  // Block, chaining and counter state.
  logic [63:0]     blk_q;
  logic [63:0]     chain_q, chain_d;
  logic [63:0]     ctr_q, ctr_d;
  // Round unit state.
  logic [31:0]     v0_q, v0_d, v1_q, v1_d, sum_q, sum_d;
  logic [RndW-1:0] cnt_q, cnt_d;
  // Output register.
  xtea_pkg::out_item_t out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic [RndW-1:0] eff_rounds;
  logic [CmpW-1:0] rc_ext, max_ext;
  logic            decrypt;
  logic [63:0]     core_in, core_out, result;
  logic [31:0]     s_next, t0, t1, v_half;

  // Effective round count: round_count saturated at MaxRounds.
  assign rc_ext     = CmpW'(cfg_i.round_count);
  assign max_ext    = CmpW'(MaxRounds);
  assign eff_rounds = (rc_ext > max_ext) ? RndW'(max_ext) : RndW'(rc_ext);

  assign decrypt = (cfg_i.mode == xtea_pkg::MODE_DEC) ||
                   (cfg_i.mode == xtea_pkg::MODE_CBC_DEC);

  // Block entering the cipher core for the current mode.
  always_comb begin
    unique case (cfg_i.mode)
      xtea_pkg::MODE_CBC_ENC: core_in = blk_q ^ chain_q;
      xtea_pkg::MODE_CTR:     core_in = chain_q ^ ctr_q;
      default:                core_in = blk_q;
    endcase
  end

  // One double Feistel round, forward or inverse.
  always_comb begin
    if (decrypt) begin
      s_next = sum_q - xtea_pkg::XteaDelta;
      t0     = xtea_pkg::mix(v0_q) ^ (sum_q + cfg_i.key[sum_q[12:11]]);
      v_half = v1_q - t0;
      t1     = xtea_pkg::mix(v_half) ^ (s_next + cfg_i.key[s_next[1:0]]);
    end else begin
      s_next = sum_q + xtea_pkg::XteaDelta;
      t0     = xtea_pkg::mix(v1_q) ^ (sum_q + cfg_i.key[sum_q[1:0]]);
      v_half = v0_q + t0;
      t1     = xtea_pkg::mix(v_half) ^ (s_next + cfg_i.key[s_next[12:11]]);
    end
  end

  assign core_out = {v1_q, v0_q};

  // Result and chaining update for the current mode.
  always_comb begin
    chain_d = chain_q;
    ctr_d   = ctr_q;
    unique case (cfg_i.mode)
      xtea_pkg::MODE_CBC_ENC: begin
        result  = core_out;
        chain_d = core_out;
      end
      xtea_pkg::MODE_CBC_DEC: begin
        result  = core_out ^ chain_q;
        chain_d = blk_q;
      end
      xtea_pkg::MODE_CTR: begin
        result = blk_q ^ core_out;
        ctr_d  = ctr_q + 64'd1;
      end
      default: result = core_out;
    endcase
    // A restart at accept reloads the chaining value and clears the counter.
    if (cmd_i.accept && in_data_i.restart_chain) begin
      chain_d = cfg_i.chain_init;
      ctr_d   = '0;
    end else if (!cmd_i.finish) begin
      chain_d = chain_q;
      ctr_d   = ctr_q;
    end
  end

  // Round unit next values.
  always_comb begin
    v0_d  = v0_q;
    v1_d  = v1_q;
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      v0_d  = core_in[31:0];
      v1_d  = core_in[63:32];
      sum_d = decrypt ? 32'(xtea_pkg::XteaDelta * 32'(eff_rounds)) : 32'd0;
      cnt_d = eff_rounds;
    end else if (cmd_i.step) begin
      if (decrypt) begin
        v1_d = v_half;
        v0_d = v0_q - t1;
      end else begin
        v0_d = v_half;
        v1_d = v1_q + t1;
      end
      sum_d = s_next;
      cnt_d = cnt_q - RndW'(1);
    end
  end

  // Output register: written at finish, emptied when the transaction is taken.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_i.finish) begin
      out_d.out_low  = result[31:0];
      out_d.out_high = result[63:32];
      out_valid_d    = 1'b1;
    end
  end

  // Control state and chaining state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= '0;
      ctr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chain_q     <= chain_d;
      ctr_q       <= ctr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      blk_q <= {in_data_i.word_high, in_data_i.word_low};
    end
    v0_q  <= v0_d;
    v1_q  <= v1_d;
    sum_q <= sum_d;
    out_q <= out_d;
  end

  // Status to the controller.
  assign sts_o.rounds_zero = (eff_rounds == '0);
  assign sts_o.last_round  = (cnt_q == RndW'(1));
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A round is only run while rounds remain.
  `ASSERT_NEVER(a_step_without_rounds, cmd_i.step && (cnt_q == '0))
  // Finishing a block always presents a result next cycle.
  `ASSERT_CLK(a_finish_sets_valid, cmd_i.finish |=> out_valid_q)

endmodule

/* hw/rtl/xtea_cipher_with_modes.sv */
// XTEA block cipher with plain, CBC and CTR modes. A block of n = min(round_count,
// MAX_ROUNDS) double rounds passes through the idle state in which it is accepted,
// a load state, one double Feistel round per cycle in the single round unit, and
// a finish state that writes the result register and, in the CBC and CTR modes,
// updates the chaining value or counter. The finish state waits for as long as an
// earlier result is held in the output register by a stall. A new block is
// accepted once the previous one is finished, even while its result still waits
// in the output register. Configure the key, mode, round count and IV/nonce only
// while idle.
// Top level: instantiates xtea_regs, xtea_ctrl and xtea_dp; depends on xtea_pkg.
module xtea_cipher_with_modes #(
  parameter int unsigned MAX_ROUNDS = xtea_pkg::MaxRoundsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input block channel.
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  xtea_pkg::in_item_t          in_data_i,
  // Result block channel.
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output xtea_pkg::out_item_t         out_data_o,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xtea_pkg::PaddrW-1:0] paddr,
  input  logic [xtea_pkg::PdataW-1:0] pwdata,
  output logic [xtea_pkg::PdataW-1:0] prdata,
  output logic                        pready
);

  xtea_pkg::cfg_t    cfg;
  xtea_pkg::dp_cmd_t cmd;
  xtea_pkg::dp_sts_t sts;

  // Configuration registers.
  xtea_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencing of accept, load, rounds and finish.
  xtea_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Round unit, chaining state and output register.
  xtea_dp #(
    .MaxRounds (MAX_ROUNDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sim/xtea_cipher_with_modes_test.sv */
// Self-checking testbench for the XTEA cipher with plain, CBC and CTR modes.
// Drives blocks over the valid/stall channel, configures over APB, and predicts
// every result block in-line. Depends on xtea_pkg and xtea_cipher_with_modes.
module xtea_cipher_with_modes_test;

  localparam int unsigned RoundLimit = xtea_pkg::MaxRoundsDefault;
  localparam int unsigned PhaseBlocks = 100;
  localparam int unsigned RandomPhases = 14;
  localparam int unsigned PrintLimit = 40;

  // Clock, reset and block ports.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  xtea_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  xtea_pkg::out_item_t out_data_o;

  // Configuration port.
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [xtea_pkg::PaddrW-1:0] paddr = '0;
  logic [xtea_pkg::PdataW-1:0] pwdata = '0;
  logic [xtea_pkg::PdataW-1:0] prdata;
  logic pready;

  // Predicted configuration and chaining state.
  logic [31:0] cfg_key [4];
  logic [2:0] cfg_mode;
  logic [6:0] cfg_rounds;
  logic [63:0] cfg_chain_init;
  logic [63:0] chain_q;
  logic [63:0] ctr_q;

  // Result blocks still owed by the block, oldest first.
  xtea_pkg::out_item_t pending_blocks[$];
  xtea_pkg::out_item_t want_block;

  int unsigned err_count = 0;
  int unsigned n_blocks = 0;
  int unsigned n_results = 0;
  int unsigned n_writes = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_kind = 0;

  xtea_cipher_with_modes #(
    .MAX_ROUNDS(RoundLimit)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Free-running clock, period 12.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Hard limit on the run time.
  initial begin
    #12_000_000;
    $display("TIMEOUT at %0t", $time);
    $display("DONE: errors detected");
    $finish;
  end

  // One line per failure; the count keeps going once printing stops.
  task automatic report_error(string msg);
    if (err_count < PrintLimit) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
    err_count++;
  endtask

  // Predictor: one double Feistel iteration mixes each half with the other.
  function automatic logic [31:0] mix_word(logic [31:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

  function automatic int unsigned active_rounds();
    int unsigned r;
    r = 32'(cfg_rounds);
    if (r > RoundLimit) begin
      r = RoundLimit;
    end
    return r;
  endfunction

  function automatic logic [63:0] encrypt_block(logic [63:0] blk);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] s;
    int unsigned n;
    v0 = blk[31:0];
    v1 = blk[63:32];
    s = '0;
    n = active_rounds();
    for (int unsigned i = 0; i < n; i++) begin
      v0 += mix_word(v1) ^ (s + cfg_key[s[1:0]]);
      s += xtea_pkg::XteaDelta;
      v1 += mix_word(v0) ^ (s + cfg_key[s[12:11]]);
    end
    return {v1, v0};
  endfunction

  function automatic logic [63:0] decrypt_block(logic [63:0] blk);
    logic [31:0] v0;
    logic [31:0] v1;
    logic [31:0] s;
    int unsigned n;
    v0 = blk[31:0];
    v1 = blk[63:32];
    n = active_rounds();
    s = xtea_pkg::XteaDelta * n;
    for (int unsigned i = 0; i < n; i++) begin
      v1 -= mix_word(v0) ^ (s + cfg_key[s[12:11]]);
      s -= xtea_pkg::XteaDelta;
      v0 -= mix_word(v1) ^ (s + cfg_key[s[1:0]]);
    end
    return {v1, v0};
  endfunction

  // Computes the result block of one input block and advances the chaining state.
  function automatic xtea_pkg::out_item_t cipher_predict(xtea_pkg::in_item_t item);
    logic [63:0] blk;
    logic [63:0] res;
    xtea_pkg::out_item_t o;
    blk = {item.word_high, item.word_low};
    if (item.restart_chain) begin
      chain_q = cfg_chain_init;
      ctr_q = '0;
    end
    case (cfg_mode)
      xtea_pkg::MODE_DEC: begin
        res = decrypt_block(blk);
      end
      xtea_pkg::MODE_CBC_ENC: begin
        res = encrypt_block(blk ^ chain_q);
        chain_q = res;
      end
      xtea_pkg::MODE_CBC_DEC: begin
        res = decrypt_block(blk) ^ chain_q;
        chain_q = blk;
      end
      xtea_pkg::MODE_CTR: begin
        res = blk ^ encrypt_block(chain_q ^ ctr_q);
        ctr_q = ctr_q + 64'd1;
      end
      default: begin
        res = encrypt_block(blk);
      end
    endcase
    o.out_low = res[31:0];
    o.out_high = res[63:32];
    return o;
  endfunction

  // Predicted register contents, as a read should return them.
  function automatic logic [63:0] reg_value(xtea_pkg::reg_idx_e idx);
    case (idx)
      xtea_pkg::REG_KEY0: return {32'h0, cfg_key[0]};
      xtea_pkg::REG_KEY1: return {32'h0, cfg_key[1]};
      xtea_pkg::REG_KEY2: return {32'h0, cfg_key[2]};
      xtea_pkg::REG_KEY3: return {32'h0, cfg_key[3]};
      xtea_pkg::REG_MODE: return {61'h0, cfg_mode};
      xtea_pkg::REG_ROUNDS: return {57'h0, cfg_rounds};
      default: return cfg_chain_init;
    endcase
  endfunction

  function automatic logic [63:0] reg_mask(xtea_pkg::reg_idx_e idx);
    case (idx)
      xtea_pkg::REG_MODE: return 64'h7;
      xtea_pkg::REG_ROUNDS: return 64'h7F;
      xtea_pkg::REG_CHAIN_INIT: return '1;
      default: return 64'hFFFF_FFFF;
    endcase
  endfunction

  function automatic void apply_reg(xtea_pkg::reg_idx_e idx, logic [63:0] val);
    case (idx)
      xtea_pkg::REG_KEY0: cfg_key[0] = val[31:0];
      xtea_pkg::REG_KEY1: cfg_key[1] = val[31:0];
      xtea_pkg::REG_KEY2: cfg_key[2] = val[31:0];
      xtea_pkg::REG_KEY3: cfg_key[3] = val[31:0];
      xtea_pkg::REG_MODE: cfg_mode = val[2:0];
      xtea_pkg::REG_ROUNDS: cfg_rounds = val[6:0];
      default: cfg_chain_init = val;
    endcase
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 15))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // APB write: setup cycle, then access cycle until pready. Entered at a falling edge.
  task automatic apb_write(xtea_pkg::reg_idx_e idx, logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, val);
    n_writes++;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // APB read, checked against the predicted register contents.
  task automatic apb_read_check(xtea_pkg::reg_idx_e idx);
    logic [63:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 3'b000};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata & reg_mask(idx);
    if (got !== reg_value(idx)) begin
      report_error($sformatf("register %s read %h, want %h", idx.name(), got,
                             reg_value(idx)));
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sends one block and records its expected result. Entered and left at a
  // falling edge; between bursts the sender idles for a random gap.
  task automatic send_block(logic [31:0] lo, logic [31:0] hi, logic restart);
    xtea_pkg::in_item_t item;
    int unsigned gap;
    item.word_low = lo;
    item.word_high = hi;
    item.restart_chain = restart;
    in_data_i <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_blocks.push_back(cipher_predict(item));
    n_blocks++;
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Waits until every expected block has come back and the block is idle.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_blocks.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Reset values, then extreme values written and read back.
  task automatic test_register_access();
    xtea_pkg::reg_idx_e r;
    r = r.first();
    do begin
      apb_read_check(r);
      r = r.next();
    end while (r != r.first());
    apb_write(xtea_pkg::REG_KEY0, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(xtea_pkg::REG_KEY1, 64'h0);
    apb_write(xtea_pkg::REG_KEY2, 64'hFFFF_FFFF);
    apb_write(xtea_pkg::REG_KEY3, 64'hA5A5_A5A5_5A5A_5A5A);
    apb_write(xtea_pkg::REG_MODE, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(xtea_pkg::REG_ROUNDS, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(xtea_pkg::REG_CHAIN_INIT, 64'hFFFF_FFFF_FFFF_FFFF);
    r = r.first();
    do begin
      apb_read_check(r);
      r = r.next();
    end while (r != r.first());
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_ENC));
    apb_write(xtea_pkg::REG_ROUNDS, 64'(xtea_pkg::RoundCountReset));
    apb_write(xtea_pkg::REG_CHAIN_INIT, 64'h0);
  endtask

  // Plain encrypt on the extremes of the block words, with an all-zero key.
  task automatic test_plain_extremes();
    apb_write(xtea_pkg::REG_KEY0, 64'h0);
    apb_write(xtea_pkg::REG_KEY2, 64'h0);
    apb_write(xtea_pkg::REG_KEY3, 64'h0);
    send_block(32'h0, 32'h0, 1'b0);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    settle_idle();
  endtask

  // CBC, CTR and plain decrypt messages, including a chained block before any restart.
  task automatic test_chaining_modes();
    apb_write(xtea_pkg::REG_KEY0, 64'h0123_4567);
    apb_write(xtea_pkg::REG_KEY1, 64'h89AB_CDEF);
    apb_write(xtea_pkg::REG_KEY2, 64'hFEDC_BA98);
    apb_write(xtea_pkg::REG_KEY3, 64'h7654_3210);
    apb_write(xtea_pkg::REG_CHAIN_INIT, 64'hFFFF_FFFF_FFFF_FFFF);
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_CBC_ENC));
    send_block(32'h1111_1111, 32'h2222_2222, 1'b0);
    send_block(32'hFFFF_FFFF, 32'h0, 1'b1);
    send_block(32'h0, 32'hFFFF_FFFF, 1'b0);
    settle_idle();
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_CBC_DEC));
    send_block($urandom, $urandom, 1'b1);
    send_block($urandom, $urandom, 1'b0);
    send_block($urandom, $urandom, 1'b0);
    settle_idle();
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_CTR));
    send_block(32'h0, 32'h0, 1'b1);
    send_block(32'h0, 32'h0, 1'b0);
    send_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    settle_idle();
    // Plain decrypt leaves the chain alone, apart from a restart.
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_DEC));
    send_block($urandom, $urandom, 1'b1);
    send_block($urandom, $urandom, 1'b0);
    settle_idle();
  endtask

  // Mode codes past CTR behave as plain encrypt.
  task automatic test_unused_modes();
    for (int m = int'(xtea_pkg::MODE_CTR) + 1; m < 8; m++) begin
      apb_write(xtea_pkg::REG_MODE, 64'(m));
      send_block($urandom, $urandom, m[0]);
      settle_idle();
    end
  endtask

  // Zero rounds pass the block through; counts above the limit saturate.
  task automatic test_round_limits();
    apb_write(xtea_pkg::REG_ROUNDS, 64'h0);
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_ENC));
    send_block($urandom, $urandom, 1'b0);
    settle_idle();
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_DEC));
    send_block($urandom, $urandom, 1'b0);
    settle_idle();
    apb_write(xtea_pkg::REG_ROUNDS, 64'h7F);
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_ENC));
    send_block($urandom, $urandom, 1'b0);
    settle_idle();
    apb_write(xtea_pkg::REG_ROUNDS, 64'h1);
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_DEC));
    send_block($urandom, $urandom, 1'b0);
    settle_idle();
    apb_write(xtea_pkg::REG_ROUNDS, 64'(RoundLimit));
    apb_write(xtea_pkg::REG_MODE, 64'(xtea_pkg::MODE_CTR));
    send_block($urandom, $urandom, 1'b1);
    settle_idle();
  endtask

  // Random phases: a fresh configuration each, then messages of random length.
  // Most messages start with a restart; the rest restart at random points.
  task automatic test_random_traffic();
    logic [63:0] val;
    int unsigned sent;
    int unsigned msg_len;
    bit noisy;
    for (int unsigned p = 0; p < RandomPhases; p++) begin
      settle_idle();
      apb_write(xtea_pkg::REG_KEY0, {$urandom, rand_word()});
      apb_write(xtea_pkg::REG_KEY1, {$urandom, rand_word()});
      apb_write(xtea_pkg::REG_KEY2, {$urandom, rand_word()});
      apb_write(xtea_pkg::REG_KEY3, {$urandom, rand_word()});
      val = {$urandom, $urandom};
      val[2:0] = ($urandom_range(0, 7) == 0)
                 ? 3'($urandom_range(int'(xtea_pkg::MODE_CTR) + 1, 7))
                 : 3'($urandom_range(0, int'(xtea_pkg::MODE_CTR)));
      apb_write(xtea_pkg::REG_MODE, val);
      // Mostly short round counts keep the run fast; a few hit the limits.
      val = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        6, 7: val[6:0] = xtea_pkg::RoundCountReset;
        8: val[6:0] = 7'(RoundLimit);
        9: val[6:0] = ($urandom_range(0, 1) == 0) ? 7'd0
                                                  : 7'($urandom_range(RoundLimit + 1, 127));
        default: val[6:0] = 7'($urandom_range(1, 12));
      endcase
      apb_write(xtea_pkg::REG_ROUNDS, val);
      apb_write(xtea_pkg::REG_CHAIN_INIT, {rand_word(), rand_word()});
      apb_read_check(xtea_pkg::REG_MODE);
      apb_read_check(xtea_pkg::REG_ROUNDS);
      sent = 0;
      while (sent < PhaseBlocks) begin
        msg_len = $urandom_range(1, 12);
        noisy = ($urandom_range(0, 6) == 0);
        for (int unsigned b = 0; b < msg_len; b++) begin
          send_block(rand_word(), rand_word(),
                     noisy ? ($urandom_range(0, 3) == 0) : (b == 0));
        end
        sent += msg_len;
      end
    end
    settle_idle();
  endtask

  // Receiver stalls in windows: none, solid, or random.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = (stall_kind == 1) ? $urandom_range(1, 6) : $urandom_range(5, 60);
    end
    stall_left--;
    case (stall_kind)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= 1'b1;
      default: out_stall_i <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Each accepted result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_blocks.size() == 0) begin
        report_error($sformatf("unexpected result %h", out_data_o));
      end else begin
        want_block = pending_blocks.pop_front();
        if (out_data_o.out_low !== want_block.out_low) begin
          report_error($sformatf("out_low %h, want %h",
                                 out_data_o.out_low, want_block.out_low));
        end
        if (out_data_o.out_high !== want_block.out_high) begin
          report_error($sformatf("out_high %h, want %h",
                                 out_data_o.out_high, want_block.out_high));
        end
      end
    end
  end

  // Test sequence.
  initial begin
    int unsigned guard;
    cfg_key[0] = '0;
    cfg_key[1] = '0;
    cfg_key[2] = '0;
    cfg_key[3] = '0;
    cfg_mode = xtea_pkg::MODE_ENC;
    cfg_rounds = xtea_pkg::RoundCountReset;
    cfg_chain_init = '0;
    chain_q = '0;
    ctr_q = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_register_access();
    test_plain_extremes();
    test_chaining_modes();
    test_unused_modes();
    test_round_limits();
    test_random_traffic();

    // Drain, then watch for stray results.
    guard = 0;
    while (pending_blocks.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    if (pending_blocks.size() != 0) begin
      report_error($sformatf("%0d result blocks never arrived", pending_blocks.size()));
    end
    repeat (100) @(posedge clk_i);

    $display("Sent %0d blocks and checked %0d results over %0d register writes,",
             n_blocks, n_results, n_writes);
    $display("covering all mode codes, restarts, and round counts from 0 to 127.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
